FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clock; only ASSERT_CLK is gated by reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: rtl/core/spfq_pkg.sv
// ----------------------------------------------------------------------------
// spfq_pkg
// shared constants and codes of the strict priority level queue
// ----------------------------------------------------------------------------
package spfq_pkg;

   localparam int LEVELS       = 5;
   localparam int LEVEL_DEPTH  = 16;
   localparam int HANDLE_W     = 16;

   localparam int LVL_W        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int PTR_W        = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W        = $clog2(LEVEL_DEPTH + 1);
   localparam int THR_W        = 5;
   localparam int CMP_W        = (CNT_W > THR_W) ? CNT_W : THR_W;

   // port widths fixed by the interface
   localparam int HANDLE_PORT_W = 16;
   localparam int PRIO_W        = 3;
   localparam int LEVEL_PORT_W  = 3;
   localparam int MASK_W        = 5;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(5);

   typedef enum logic [0:0] {
      CMD_ENQUEUE = 1'b0,
      CMD_SERVE   = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_SERVED   = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

endpackage

FILE: rtl/core/strict_priority_five_level_queue.sv
// ----------------------------------------------------------------------------
// strict_priority_five_level_queue
// five fifo levels of item handles; enqueue by priority, serve most urgent
//
//   channel   handshake            payload
//   request   start / busy         req_cmd, req_item_handle, req_priority_req
//   response  rsp_strobe           rsp_status, rsp_served_handle,
//                                  rsp_served_level, rsp_saturated_levels
//   csr       csr_wr_en            csr_wr_data (saturation threshold)
//
// a beat accepted at one edge gives its response in the very next cycle,
// one request per cycle while busy is low; the read of the entry memory
// is registered. busy is high only during reset and the cycle after it.
// the response is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module strict_priority_five_level_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_cmd,
   input  logic [spfq_pkg::HANDLE_PORT_W-1:0]   req_item_handle,
   input  logic [spfq_pkg::PRIO_W-1:0]          req_priority_req,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic [spfq_pkg::HANDLE_PORT_W-1:0]   rsp_served_handle,
   output logic [spfq_pkg::LEVEL_PORT_W-1:0]    rsp_served_level,
   output logic [spfq_pkg::MASK_W-1:0]          rsp_saturated_levels,
   input  logic                                 csr_wr_en,
   input  logic [spfq_pkg::THR_W-1:0]           csr_wr_data
);
   import spfq_pkg::*;

   `include "assert_macros.svh"

   // entry memory, one row per level
   logic [HANDLE_W-1:0] mem [LEVELS][LEVEL_DEPTH];

   logic [PTR_W-1:0]    head_ff  [LEVELS];
   logic [PTR_W-1:0]    head_in  [LEVELS];
   logic [PTR_W-1:0]    tail_ff  [LEVELS];
   logic [PTR_W-1:0]    tail_in  [LEVELS];
   logic [CNT_W-1:0]    cnt_ff   [LEVELS];
   logic [CNT_W-1:0]    cnt_in   [LEVELS];

   logic [THR_W-1:0]    thr_ff;
   logic                busy_ff;
   logic                strobe_ff;
   status_type          status_ff;
   status_type          status_in;
   logic [LVL_W-1:0]    lvl_ff;
   logic [LVL_W-1:0]    lvl_in;
   logic                lvl_valid_ff;
   logic                lvl_valid_in;
   logic [MASK_W-1:0]   sat_ff;
   logic [MASK_W-1:0]   sat_in;
   logic [HANDLE_W-1:0] rd_ff;

   logic                accept;
   logic                mem_we;
   logic                mem_re;
   logic [LVL_W-1:0]    enq_lvl;
   logic [LVL_W-1:0]    srv_lvl;
   logic                srv_found;
   cmd_type             cmd;

   assign accept = start & ~busy_ff;
   assign cmd    = cmd_type'(req_cmd);

   // priority outside 1..LEVELS lands on the least urgent level
   always_comb begin
      if (int'(req_priority_req) >= 1 && int'(req_priority_req) <= LEVELS) begin
         enq_lvl = LVL_W'(int'(req_priority_req) - 1);
      end else begin
         enq_lvl = LVL_W'(LEVELS - 1);
      end
   end

   // most urgent non-empty level
   always_comb begin
      srv_lvl   = '0;
      srv_found = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            srv_lvl   = LVL_W'(i);
            srv_found = 1'b1;
         end
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      cnt_in       = cnt_ff;
      status_in    = ST_EMPTY;
      lvl_in       = '0;
      lvl_valid_in = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      if (accept) begin
         case (cmd)
            CMD_ENQUEUE: begin
               lvl_in       = enq_lvl;
               lvl_valid_in = 1'b1;
               if (cnt_ff[enq_lvl] >= CNT_W'(LEVEL_DEPTH)) begin
                  status_in = ST_DROPPED;
               end else begin
                  status_in        = ST_ENQUEUED;
                  mem_we           = 1'b1;
                  tail_in[enq_lvl] = (tail_ff[enq_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ?
                                     '0 : tail_ff[enq_lvl] + PTR_W'(1);
                  cnt_in[enq_lvl]  = cnt_ff[enq_lvl] + CNT_W'(1);
               end
            end
            CMD_SERVE: begin
               if (srv_found) begin
                  status_in        = ST_SERVED;
                  lvl_in           = srv_lvl;
                  lvl_valid_in     = 1'b1;
                  mem_re           = 1'b1;
                  head_in[srv_lvl] = (head_ff[srv_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ?
                                     '0 : head_ff[srv_lvl] + PTR_W'(1);
                  cnt_in[srv_lvl]  = cnt_ff[srv_lvl] - CNT_W'(1);
               end
            end
            default: begin
               status_in = ST_EMPTY;
            end
         endcase
      end
   end

   // saturation flags from the counts after this beat
   always_comb begin
      sat_in = '0;
      for (int i = 0; i < LEVELS && i < MASK_W; i++) begin
         sat_in[i] = (CMP_W'(cnt_in[i]) >= CMP_W'(thr_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[enq_lvl][tail_ff[enq_lvl]] <= req_item_handle[HANDLE_W-1:0];
      end
      if (mem_re) begin
         rd_ff <= mem[srv_lvl][head_ff[srv_lvl]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
         thr_ff    <= THRESHOLD_RESET;
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
         busy_ff   <= 1'b0;
         strobe_ff <= accept;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         lvl_ff       <= lvl_in;
         lvl_valid_ff <= lvl_valid_in;
         sat_ff       <= sat_in;
      end
   end

   assign busy                 = busy_ff;
   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = status_ff;
   assign rsp_served_handle    = (status_ff == ST_SERVED) ?
                                 HANDLE_PORT_W'(rd_ff) : '0;
   assign rsp_served_level     = lvl_valid_ff ?
                                 LEVEL_PORT_W'(32'(lvl_ff) + 32'd1) : '0;
   assign rsp_saturated_levels = sat_ff;

   `ASSERT_CLK(a_strobe_follows_accept, accept |=> rsp_strobe, "accepted beat gave no response")
   `ASSERT_CLK(a_strobe_has_cause, rsp_strobe |-> $past(accept), "response without a request")
   `ASSERT_CLK(a_served_has_level, (rsp_strobe && rsp_status == ST_SERVED) |-> rsp_served_level != '0, "serve without a level")
   `ASSERT_CLK(a_drop_only_when_full, (rsp_strobe && rsp_status == ST_DROPPED) |-> $past(cnt_ff[enq_lvl]) == CNT_W'(LEVEL_DEPTH), "drop on a level that was not full")
   `ASSERT_ALWAYS(a_busy_in_reset, reset |=> busy, "busy low right after reset")

endmodule
